// File: sv/lsch_pkg.sv
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Request and result types, field widths and codes shared by the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lsch_pkg;

    localparam int DEF_SLOTS       = 16;
    localparam int DEF_TICKET_BITS = 16;

    localparam int SLOT_IDX_W = 4;
    localparam int TK_IN_W    = 16;
    localparam int RND_W      = 32;
    localparam int TOT_OUT_W  = 20;

    localparam logic [TOT_OUT_W-1:0] TOTAL_MAX = '1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DRAW  = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [TK_IN_W-1:0]    ticket_count;
        logic                  is_waiting;
        logic [RND_W-1:0]      random_value;
    } t_req;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] chosen_slot;
        logic                  found;
        logic [TOT_OUT_W-1:0]  ticket_total;
    } t_res;

endpackage

`default_nettype wire

// File: sv/lsch_store.sv
// ----------------------------------------------------------------------------
// Lottery scheduler slot store
// Ticket and waiting memory with one write port and one registered read port;
// per-slot valid bits make unwritten slots read as zero tickets, waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module lsch_store
    import lsch_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int TICKET_BITS = DEF_TICKET_BITS,
    localparam int IDX_W      = $clog2(SLOTS)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr_en,
    input  wire logic [IDX_W-1:0]       i_wr_addr,
    input  wire logic [TICKET_BITS-1:0] i_wr_tickets,
    input  wire logic                   i_wr_waiting,
    input  wire logic [IDX_W-1:0]       i_rd_addr,
    output logic      [TICKET_BITS-1:0] o_rd_tickets,
    output logic                        o_rd_waiting
);

    logic [TICKET_BITS-1:0] r_mem_tk [SLOTS];
    logic                   r_mem_wt [SLOTS];
    logic [SLOTS-1:0]       r_vld;
    logic [TICKET_BITS-1:0] r_rd_tk;
    logic                   r_rd_wt;
    logic                   r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_tk[i_wr_addr] <= i_wr_tickets;
            r_mem_wt[i_wr_addr] <= i_wr_waiting;
        end
        r_rd_tk <= r_mem_tk[i_rd_addr];
        r_rd_wt <= r_mem_wt[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= r_vld[i_rd_addr];
        end
    end

    // unwritten slots hold the reset entry
    assign o_rd_tickets = r_rd_hit ? r_rd_tk : '0;
    assign o_rd_waiting = r_rd_hit ? r_rd_wt : 1'b1;

endmodule

`default_nettype wire

// File: sv/lsch_mod.sv
// ----------------------------------------------------------------------------
// Lottery scheduler serial modulo
// Restoring remainder: shifts the random word in one bit per cycle and
// subtracts the divisor whenever the partial remainder reaches it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsch_mod
    import lsch_pkg::*;
#(
    parameter int TOT_W = DEF_TICKET_BITS + $clog2(DEF_SLOTS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [RND_W-1:0] i_dividend,
    input  wire logic [TOT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [TOT_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(RND_W);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RND_W-1:0] r_dvd;
    logic [TOT_W-1:0] r_dvs;
    logic [TOT_W-1:0] r_rem;
    logic [TOT_W:0]   w_sh;
    logic [TOT_W-1:0] n_rem;

    always_comb begin
        w_sh = {r_rem, r_dvd[RND_W-1]};
        if (w_sh >= {1'b0, r_dvs}) begin
            n_rem = TOT_W'(w_sh - {1'b0, r_dvs});
        end else begin
            n_rem = w_sh[TOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: sv/lottery_scheduler_top.sv
// ----------------------------------------------------------------------------
// Lottery scheduler
// Slot table of ticket counts and waiting flags; a draw request sums the
// tickets in play, reduces the random word modulo the sum and walks the
// slots to find the winner.
//
//   Channel   Strobe    Taken at edge with     Payload
//   request   i_start   i_start && !o_busy     i_req (t_req)
//   result    o_valid   every strobe cycle     o_res (t_res)
//
// An update request gives no result; o_busy stays low.
// A draw raises o_valid once it has summed over the store's registered read
// port, checked the sum in one state, run the 32-step bit-serial modulo to
// its done strobe and walked the slots up to the winner. A zero sum skips
// the modulo and the walk and answers from the check state. Synchronous
// active-low reset empties the table (all slots read as zero tickets,
// waiting). The result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_scheduler_top
    import lsch_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int TICKET_BITS = DEF_TICKET_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_res      o_res
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int TOT_W = TICKET_BITS + IDX_W;
    localparam int XW    = (TOT_W > TOT_OUT_W) ? TOT_W : TOT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHK,
        S_DIV,
        S_WALK
    } t_state_e;

    t_state_e               r_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [RND_W-1:0]       r_rnd;
    logic [TOT_W-1:0]       r_sum;
    logic [TOT_W-1:0]       r_run;
    logic [TOT_W-1:0]       r_pick;
    logic                   r_valid;
    t_res                   r_res;

    logic                   w_accept;
    logic                   w_wr_en;
    logic [TICKET_BITS-1:0] w_rd_tk;
    logic                   w_rd_wt;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [TOT_W-1:0]       w_rem;
    logic                   w_in_play;
    logic                   w_last;
    logic [TOT_W-1:0]       n_sum;
    logic [TOT_W-1:0]       n_run;
    logic                   w_hit;
    logic [XW-1:0]          w_sum_x;
    logic [TOT_OUT_W-1:0]   w_total;
    logic [SLOT_IDX_W-1:0]  w_winner;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_wr_en  = w_accept && (i_req.req_type == REQ_WRITE)
                      && (32'(i_req.slot_index) < SLOTS);

    lsch_store #(
        .SLOTS       (SLOTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (w_wr_en),
        .i_wr_addr    (IDX_W'(i_req.slot_index)),
        .i_wr_tickets (TICKET_BITS'(i_req.ticket_count)),
        .i_wr_waiting (i_req.is_waiting),
        .i_rd_addr    (r_cnt[IDX_W-1:0]),
        .o_rd_tickets (w_rd_tk),
        .o_rd_waiting (w_rd_wt)
    );

    assign w_div_start = (r_state == S_CHK) && (r_sum != '0);

    lsch_mod #(
        .TOT_W (TOT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_sum),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // read data trails the address through the store's read register
    always_comb begin
        w_in_play = (r_cnt != '0) && !w_rd_wt;
        w_last    = (r_cnt == CNT_W'(SLOTS));
        n_sum     = w_in_play ? TOT_W'(r_sum + TOT_W'(w_rd_tk)) : r_sum;
        n_run     = w_in_play ? TOT_W'(r_run + TOT_W'(w_rd_tk)) : r_run;
        w_hit     = w_in_play && (r_pick < n_run);
        w_sum_x   = XW'(r_sum);
        w_total   = (w_sum_x > XW'(TOTAL_MAX)) ? TOTAL_MAX : w_sum_x[TOT_OUT_W-1:0];
        w_winner  = SLOT_IDX_W'(IDX_W'(r_cnt - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_req.req_type == REQ_DRAW)) begin
                        r_rnd   <= i_req.random_value;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum <= n_sum;
                    if (w_last) begin
                        r_state <= S_CHK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHK: begin
                    if (r_sum == '0) begin
                        r_valid           <= 1'b1;
                        r_res.chosen_slot <= '0;
                        r_res.found       <= 1'b0;
                        r_res.ticket_total <= '0;
                        r_state           <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pick  <= w_rem;
                        r_run   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_run <= n_run;
                    if (w_hit || w_last) begin
                        r_valid            <= 1'b1;
                        r_res.chosen_slot  <= w_hit ? w_winner : '0;
                        r_res.found        <= w_hit;
                        r_res.ticket_total <= w_total;
                        r_state            <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while a draw is still running");

    a_found_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.found) |-> (o_res.ticket_total != '0))
        else $error("winner reported with no tickets in play");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req.req_type == REQ_DRAW)) |=> o_busy)
        else $error("draw request accepted without going busy");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("modulo finished outside its wait state");

endmodule

`default_nettype wire
